[rtl/secf_pkg.sv]
// ----------------------------------------------------------------------------
// secf_pkg
// shared constants, types and channel-to-strip map for the strip event finder
// ----------------------------------------------------------------------------
package secf_pkg;

  localparam int Strips = 128;
  localparam int FracBits = 8;
  localparam logic [15:0] CrcPoly = 16'h8408;
  localparam logic [15:0] CrcInit = 16'hffff;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CRC, ST_MAP, ST_SCAN, ST_DIV, ST_OUT, ST_EMPTY
  } state_t;

  function automatic logic [6:0] chan_to_strip(input logic [6:0] ch);
    logic [6:0] s;
    unique case (ch)
      7'd0: s = 7'd48;   7'd1: s = 7'd67;   7'd2: s = 7'd47;   7'd3: s = 7'd64;
      7'd4: s = 7'd49;   7'd5: s = 7'd68;   7'd6: s = 7'd46;   7'd7: s = 7'd65;
      7'd8: s = 7'd50;   7'd9: s = 7'd69;   7'd10: s = 7'd45;  7'd11: s = 7'd66;
      7'd12: s = 7'd51;  7'd13: s = 7'd70;  7'd14: s = 7'd44;  7'd15: s = 7'd63;
      7'd16: s = 7'd52;  7'd17: s = 7'd71;  7'd18: s = 7'd43;  7'd19: s = 7'd62;
      7'd20: s = 7'd53;  7'd21: s = 7'd72;  7'd22: s = 7'd42;  7'd23: s = 7'd61;
      7'd24: s = 7'd54;  7'd25: s = 7'd73;  7'd26: s = 7'd41;  7'd27: s = 7'd60;
      7'd28: s = 7'd55;  7'd29: s = 7'd74;  7'd30: s = 7'd40;  7'd31: s = 7'd59;
      7'd32: s = 7'd56;  7'd33: s = 7'd75;  7'd34: s = 7'd39;  7'd35: s = 7'd58;
      7'd36: s = 7'd89;  7'd37: s = 7'd76;  7'd38: s = 7'd38;  7'd39: s = 7'd57;
      7'd40: s = 7'd90;  7'd41: s = 7'd77;  7'd42: s = 7'd37;  7'd43: s = 7'd88;
      7'd44: s = 7'd91;  7'd45: s = 7'd78;  7'd46: s = 7'd36;  7'd47: s = 7'd87;
      7'd48: s = 7'd92;  7'd49: s = 7'd79;  7'd50: s = 7'd35;  7'd51: s = 7'd86;
      7'd52: s = 7'd93;  7'd53: s = 7'd80;  7'd54: s = 7'd34;  7'd55: s = 7'd85;
      7'd56: s = 7'd94;  7'd57: s = 7'd81;  7'd58: s = 7'd33;  7'd59: s = 7'd84;
      7'd60: s = 7'd95;  7'd61: s = 7'd82;  7'd62: s = 7'd32;  7'd63: s = 7'd83;
      7'd64: s = 7'd96;  7'd65: s = 7'd110; 7'd66: s = 7'd31;  7'd67: s = 7'd109;
      7'd68: s = 7'd97;  7'd69: s = 7'd111; 7'd70: s = 7'd30;  7'd71: s = 7'd108;
      7'd72: s = 7'd98;  7'd73: s = 7'd112; 7'd74: s = 7'd29;  7'd75: s = 7'd107;
      7'd76: s = 7'd99;  7'd77: s = 7'd113; 7'd78: s = 7'd28;  7'd79: s = 7'd106;
      7'd80: s = 7'd100; 7'd81: s = 7'd114; 7'd82: s = 7'd27;  7'd83: s = 7'd105;
      7'd84: s = 7'd101; 7'd85: s = 7'd115; 7'd86: s = 7'd26;  7'd87: s = 7'd104;
      7'd88: s = 7'd102; 7'd89: s = 7'd116; 7'd90: s = 7'd25;  7'd91: s = 7'd103;
      7'd92: s = 7'd7;   7'd93: s = 7'd117; 7'd94: s = 7'd24;  7'd95: s = 7'd6;
      7'd96: s = 7'd8;   7'd97: s = 7'd118; 7'd98: s = 7'd23;  7'd99: s = 7'd5;
      7'd100: s = 7'd9;  7'd101: s = 7'd119; 7'd102: s = 7'd22; 7'd103: s = 7'd4;
      7'd104: s = 7'd10; 7'd105: s = 7'd120; 7'd106: s = 7'd21; 7'd107: s = 7'd3;
      7'd108: s = 7'd11; 7'd109: s = 7'd121; 7'd110: s = 7'd20; 7'd111: s = 7'd2;
      7'd112: s = 7'd12; 7'd113: s = 7'd122; 7'd114: s = 7'd19; 7'd115: s = 7'd1;
      7'd116: s = 7'd13; 7'd117: s = 7'd123; 7'd118: s = 7'd18; 7'd119: s = 7'd126;
      7'd120: s = 7'd14; 7'd121: s = 7'd124; 7'd122: s = 7'd17; 7'd123: s = 7'd0;
      7'd124: s = 7'd15; 7'd125: s = 7'd125; 7'd126: s = 7'd16; default: s = 7'd127;
    endcase
    return s;
  endfunction

endpackage

[rtl/secf_div.sv]
// ----------------------------------------------------------------------------
// secf_div
// restoring divider, one quotient bit per cycle: (sum << frac) / size
// ----------------------------------------------------------------------------
module secf_div import secf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [13:0] sum,
  input  logic [7:0]  size,
  output logic        done,
  output logic [14:0] quot
);

  localparam int NumW = 14 + FracBits;

  logic [NumW-1:0] num;
  logic [8:0]      rem;
  logic [NumW-1:0] q;
  logic [7:0]      dvs;
  logic [4:0]      cnt;
  logic            busy;
  logic [8:0]      trial;
  logic [9:0]      diff;

  assign trial = {rem[7:0], num[NumW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign quot  = q[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(NumW);
        num  <= NumW'({sum, {FracBits{1'b0}}});
        rem  <= '0;
        q    <= '0;
        dvs  <= size;
      end else if (busy) begin
        num <= {num[NumW-2:0], 1'b0};
        if (!diff[9]) begin
          rem <= diff[8:0];
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/strip_event_crc_and_cluster_finder.sv]
// ----------------------------------------------------------------------------
// strip_event_crc_and_cluster_finder
// event crc-16 check and strip cluster finder
// ----------------------------------------------------------------------------
// One event is taken when ready is high; ready stays low until its last
// result is taken. The CRC runs one bit a cycle, the channel map fills
// the strip vector one channel a cycle, and the scan walks one strip a
// cycle, pausing at the end of each cluster for a serial division and an
// output that waits for out_ready.
module strip_event_crc_and_cluster_finder import secf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] bc_word,
  input  logic [15:0] ec_word,
  input  logic [15:0] chip_word,
  input  logic [63:0] hits_low,
  input  logic [63:0] hits_high,
  input  logic [15:0] crc_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        crc_ok,
  output logic [11:0] bunch_crossing,
  output logic [7:0]  event_count,
  output logic [3:0]  flags,
  output logic [11:0] chip_id,
  output logic        has_cluster,
  output logic [7:0]  cluster_size,
  output logic [14:0] cluster_position,
  output logic [5:0]  cluster_index,
  output logic        last
);

  state_t state, state_next;

  logic [175:0] sreg;
  logic [127:0] hits;
  logic [127:0] strip;
  logic [15:0]  crc, rx, bc, ec, chip;
  logic [7:0]   cnt;
  logic [7:0]   run;
  logic [13:0]  sum;
  logic [6:0]   nclus;
  logic         div_start, div_done;
  logic [14:0]  quot;
  logic         cur;
  logic         more;

  // eight crc words from the hit bits: high half then low half,
  // each half 63..48 first
  function automatic logic [127:0] hits_reorder(input logic [127:0] h);
    logic [127:0] r;
    r = {h[15:0], h[31:16], h[47:32], h[63:48],
         h[79:64], h[95:80], h[111:96], h[127:112]};
    return r;
  endfunction

  secf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .sum(sum), .size(run),
    .done(div_done), .quot(quot)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT) || (state == ST_EMPTY);
  assign cur       = (cnt < 8'd128) && strip[cnt[6:0]];
  // another run exists at or above the current position
  assign more      = |(strip >> cnt);

  assign crc_ok         = (crc == rx);
  assign bunch_crossing = bc[11:0];
  assign event_count    = ec[11:4];
  assign flags          = ec[3:0];
  assign chip_id        = chip[11:0];
  assign has_cluster    = (state == ST_OUT);
  assign cluster_size   = (state == ST_OUT) ? run : 8'd0;
  assign cluster_position = (state == ST_OUT) ? quot : 15'd0;
  assign cluster_index  = (state == ST_OUT) ? nclus[5:0] : 6'd0;
  assign last           = (state == ST_EMPTY) || !more;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CRC;
      ST_CRC:   if (cnt == 8'd175) state_next = ST_MAP;
      ST_MAP:   if (cnt == 8'd127) state_next = ST_SCAN;
      ST_SCAN: begin
        if (!cur && run != 8'd0) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else if (cnt == 8'd128) begin
          state_next = (nclus == 7'd0) ? ST_EMPTY : ST_IDLE;
        end
      end
      ST_DIV:   if (div_done) state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = more ? ST_SCAN : ST_IDLE;
      ST_EMPTY: if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        sreg  <= {hits_reorder({hits_high, hits_low}), chip_word, ec_word, bc_word};
        hits  <= {hits_high, hits_low};
        bc    <= bc_word;
        ec    <= ec_word;
        chip  <= chip_word;
        rx    <= crc_word;
        crc   <= CrcInit;
        cnt   <= '0;
        strip <= '0;
        run   <= '0;
        sum   <= '0;
        nclus <= '0;
      end
      ST_CRC: begin
        // hits_high words go out high word first, low bit first
        crc <= (crc[0] == sreg[0]) ? (crc >> 1) : ((crc >> 1) ^ CrcPoly);
        if (cnt == 8'd175) cnt <= '0;
        else               cnt <= cnt + 8'd1;
        sreg <= sreg >> 1;
      end
      ST_MAP: begin
        if (hits[cnt[6:0]]) strip[chan_to_strip(cnt[6:0])] <= 1'b1;
        cnt <= (cnt == 8'd127) ? 8'd0 : cnt + 8'd1;
      end
      ST_SCAN: begin
        if (cur) begin
          run <= run + 8'd1;
          sum <= sum + {7'd0, cnt[6:0]};
          cnt <= cnt + 8'd1;
        end else if (run == 8'd0 && cnt != 8'd128) begin
          cnt <= cnt + 8'd1;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          nclus <= nclus + 7'd1;
          run   <= '0;
          sum   <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
